[hw/rtl/irpd_pkg.sv]
// Shared types and constants for the infrared pulse-distance transmitter.
// Holds the phase encoding, register map, beat layouts and state structs.
// No dependencies.
package irpd_pkg;

  // Fixed field widths of the stream beats and the register file
  localparam int CODE_WORD_W  = 22;
  localparam int REPEAT_W     = 8;
  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_TDATA_W  = 8;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 20;
  localparam int HALF_W       = 6;
  localparam int CYCLES_W     = 8;
  localparam int SPACE_W      = 12;
  localparam int TICK_W       = 20;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CARRIER_HALF = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_CYC   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MARK_CYC     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_END_GAP      = 3'd5;

  // Register reset values
  localparam logic [HALF_W-1:0]   RST_CARRIER_HALF = 6'd14;
  localparam logic [CYCLES_W-1:0] RST_HEADER_CYC   = 8'd90;
  localparam logic [CYCLES_W-1:0] RST_MARK_CYC     = 8'd21;
  localparam logic [SPACE_W-1:0]  RST_ZERO_SPACE   = 12'd380;
  localparam logic [SPACE_W-1:0]  RST_ONE_SPACE    = 12'd850;
  localparam logic [TICK_W-1:0]   RST_END_GAP      = 20'd205000;

  // Input beat kinds carried in tuser
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SPACE,
    PH_MARK,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic [HALF_W-1:0]   carrier_half;
    logic [CYCLES_W-1:0] header_cycles;
    logic [CYCLES_W-1:0] mark_cycles;
    logic [SPACE_W-1:0]  zero_space;
    logic [SPACE_W-1:0]  one_space;
    logic [TICK_W-1:0]   end_gap;
  } cfg_t;

  // Sequencer state apart from the code and bit position
  typedef struct packed {
    phase_t              phase;
    logic [REPEAT_W-1:0] repeats;
    logic [TICK_W-1:0]   tick_count;
    logic [CYCLES_W-1:0] carrier_count;
    logic [HALF_W-1:0]   half_count;
    logic                line;
  } ctrl_t;

  // Segment the sequencer lands in after skipping empty ones
  typedef struct packed {
    phase_t              phase;
    logic [REPEAT_W-1:0] repeats;
  } land_t;

  // Result beat, ir_level in the lowest bit
  typedef struct packed {
    logic start_rejected;
    logic busy_res;
    logic ir_level;
  } res_t;

endpackage

[hw/rtl/irpd_seg_finder.sv]
// Next-segment finder: from the end of a segment, skips every zero-length
// header, space, mark and gap and names the segment the current tick lands in.
// Depends on irpd_pkg.
module irpd_seg_finder #(
  parameter int CODE_BITS = 22,
  localparam int IDX_W = $clog2(CODE_BITS + 1)
) (
  input  logic                           from_gap,
  input  logic [IDX_W-1:0]               start_idx,
  input  logic [irpd_pkg::REPEAT_W-1:0]  repeats,
  input  logic [CODE_BITS-1:0]           code,
  input  irpd_pkg::cfg_t                 cfg,
  output irpd_pkg::land_t                land,
  output logic [IDX_W-1:0]               land_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_BITS);

  logic [CODE_BITS-1:0]          nz;
  logic [CODE_BITS-1:0]          elig;
  logic                          nz_start;
  logic [IDX_W-1:0]              first_a;
  logic [IDX_W-1:0]              first_0;
  logic                          mark_nz;
  logic [irpd_pkg::REPEAT_W-1:0] rep_dec;

  assign mark_nz = (cfg.mark_cycles != '0);
  assign rep_dec = (repeats != '0) ? repeats - irpd_pkg::REPEAT_W'(1) : '0;

  // Mark the bits whose space takes line time, in transmit order
  always_comb begin
    nz_start = 1'b0;
    for (int j = 0; j < CODE_BITS; j++) begin
      nz[j]   = code[CODE_BITS-1-j] ? (cfg.one_space != '0) : (cfg.zero_space != '0);
      elig[j] = nz[j] && (IDX_W'(j) >= start_idx);
      if (IDX_W'(j) == start_idx) begin
        nz_start = nz[j];
      end
    end
  end

  // Earliest non-empty space from the start position and from bit zero
  always_comb begin
    first_a = '0;
    first_0 = '0;
    for (int j = CODE_BITS - 1; j >= 0; j--) begin
      if (elig[j]) begin
        first_a = IDX_W'(j);
      end
      if (nz[j]) begin
        first_0 = IDX_W'(j);
      end
    end
  end

  // Walk space, gap and repeat decisions
  always_comb begin
    logic go_gap;
    logic go_rep;
    go_gap   = 1'b0;
    go_rep   = from_gap;
    land     = '{phase: irpd_pkg::PH_IDLE, repeats: repeats};
    land_idx = '0;
    if (!from_gap) begin
      if (start_idx >= LAST_IDX) begin
        go_gap = 1'b1;
      end else if (mark_nz) begin
        land.phase = nz_start ? irpd_pkg::PH_SPACE : irpd_pkg::PH_MARK;
        land_idx   = start_idx;
      end else if (|elig) begin
        land.phase = irpd_pkg::PH_SPACE;
        land_idx   = first_a;
      end else begin
        go_gap = 1'b1;
      end
    end
    if (go_gap) begin
      if (cfg.end_gap != '0) begin
        land.phase = irpd_pkg::PH_GAP;
        land_idx   = LAST_IDX;
      end else begin
        go_rep = 1'b1;
      end
    end
    if (go_rep) begin
      land.repeats = rep_dec;
      land_idx     = '0;
      if (rep_dec == '0) begin
        land.phase = irpd_pkg::PH_IDLE;
      end else if (cfg.header_cycles != '0) begin
        land.phase = irpd_pkg::PH_HEADER;
      end else if (mark_nz) begin
        land.phase = nz[0] ? irpd_pkg::PH_SPACE : irpd_pkg::PH_MARK;
      end else if (|nz) begin
        land.phase = irpd_pkg::PH_SPACE;
        land_idx   = first_0;
      end else if (cfg.end_gap != '0) begin
        // A frame with no bit time goes straight to its gap
        land.phase = irpd_pkg::PH_GAP;
        land_idx   = LAST_IDX;
      end else begin
        // A frame with no line time burns every remaining repeat at once
        land.phase   = irpd_pkg::PH_IDLE;
        land.repeats = '0;
      end
    end
  end

endmodule

[hw/rtl/irpd_step.sv]
// Per-beat next-state logic: start handling, carrier burst timing, space
// and gap counting, and landing after an ended segment.
// Depends on irpd_pkg and irpd_seg_finder.
module irpd_step #(
  parameter int CODE_BITS = 22,
  localparam int IDX_W = $clog2(CODE_BITS + 1)
) (
  input  irpd_pkg::ctrl_t                        ctrl,
  input  logic [CODE_BITS-1:0]                   code_shift,
  input  logic [IDX_W-1:0]                       bit_index,
  input  irpd_pkg::cfg_t                         cfg,
  input  logic                                   mode,
  input  logic [irpd_pkg::CODE_WORD_W-1:0]       code_word,
  input  logic [irpd_pkg::REPEAT_W-1:0]          repeat_count,
  output irpd_pkg::ctrl_t                        ctrl_next,
  output logic [CODE_BITS-1:0]                   code_shift_next,
  output logic [IDX_W-1:0]                       bit_index_next,
  output irpd_pkg::res_t                         res
);

  logic [CODE_BITS-1:0]          load_code;
  logic [irpd_pkg::HALF_W-1:0]   half_len;
  logic                          cur_bit;
  logic [irpd_pkg::SPACE_W-1:0]  space_len;
  logic [irpd_pkg::CYCLES_W-1:0] burst_n;
  logic                          burst_done;
  logic                          fnd_from_gap;
  logic [IDX_W-1:0]              fnd_start;
  irpd_pkg::land_t               fnd_land;
  logic [IDX_W-1:0]              fnd_idx;

  // Mask the code to the transmitted width
  for (genvar i = 0; i < CODE_BITS; i++) begin : g_load
    if (i < irpd_pkg::CODE_WORD_W) begin : g_bit
      assign load_code[i] = code_word[i];
    end else begin : g_zero
      assign load_code[i] = 1'b0;
    end
  end

  assign half_len = (cfg.carrier_half == '0) ? irpd_pkg::HALF_W'(1) : cfg.carrier_half;

  // Bit under transmission, most significant first
  always_comb begin
    cur_bit = 1'b0;
    for (int j = 0; j < CODE_BITS; j++) begin
      if (IDX_W'(j) == bit_index) begin
        cur_bit = code_shift[CODE_BITS-1-j];
      end
    end
  end

  assign space_len  = cur_bit ? cfg.one_space : cfg.zero_space;
  assign burst_n    = (ctrl.phase == irpd_pkg::PH_HEADER) ? cfg.header_cycles
                                                          : cfg.mark_cycles;
  assign burst_done = (ctrl.half_count == '0) && !ctrl.line &&
                      (ctrl.carrier_count >= burst_n);

  // Header ends into this bit's space; mark and space end into the next bit
  assign fnd_from_gap = (ctrl.phase == irpd_pkg::PH_GAP);
  assign fnd_start    = (ctrl.phase == irpd_pkg::PH_HEADER) ? bit_index
                                                            : bit_index + IDX_W'(1);

  irpd_seg_finder #(
    .CODE_BITS (CODE_BITS)
  ) u_finder (
    .from_gap  (fnd_from_gap),
    .start_idx (fnd_start),
    .repeats   (ctrl.repeats),
    .code      (code_shift),
    .cfg       (cfg),
    .land      (fnd_land),
    .land_idx  (fnd_idx)
  );

  always_comb begin
    logic                          land_en;
    irpd_pkg::phase_t              lp;
    logic [IDX_W-1:0]              li;
    logic [irpd_pkg::REPEAT_W-1:0] lr;
    logic                          lvl;
    logic [irpd_pkg::HALF_W:0]     hc;
    ctrl_next       = ctrl;
    code_shift_next = code_shift;
    bit_index_next  = bit_index;
    res             = '0;
    land_en         = 1'b0;
    lp              = fnd_land.phase;
    li              = fnd_idx;
    lr              = fnd_land.repeats;
    lvl             = 1'b0;
    hc              = '0;
    if (mode == irpd_pkg::MODE_START) begin
      // Drop a start while busy or with no frames asked for
      if (ctrl.phase != irpd_pkg::PH_IDLE || repeat_count == '0) begin
        res.start_rejected = 1'b1;
      end else begin
        code_shift_next         = load_code;
        bit_index_next          = '0;
        ctrl_next.phase         = irpd_pkg::PH_HEADER;
        ctrl_next.repeats       = repeat_count;
        ctrl_next.tick_count    = '0;
        ctrl_next.carrier_count = '0;
        ctrl_next.half_count    = '0;
        ctrl_next.line          = 1'b0;
      end
    end else begin
      case (ctrl.phase)
        irpd_pkg::PH_HEADER, irpd_pkg::PH_MARK: begin
          if (burst_done) begin
            land_en = 1'b1;
          end else begin
            // Toggle at each half-period start, count cycles on the low half
            lvl = (ctrl.half_count == '0) ? ~ctrl.line : ctrl.line;
            hc  = {1'b0, ctrl.half_count} + (irpd_pkg::HALF_W + 1)'(1);
            ctrl_next.line = lvl;
            if (hc >= {1'b0, half_len}) begin
              ctrl_next.half_count = '0;
              if (!lvl) begin
                ctrl_next.carrier_count = ctrl.carrier_count + irpd_pkg::CYCLES_W'(1);
              end
            end else begin
              ctrl_next.half_count = hc[irpd_pkg::HALF_W-1:0];
            end
          end
        end
        irpd_pkg::PH_SPACE: begin
          if (ctrl.tick_count >= irpd_pkg::TICK_W'(space_len)) begin
            land_en = 1'b1;
            if (cfg.mark_cycles != '0) begin
              // Non-empty mark follows directly
              lp = irpd_pkg::PH_MARK;
              li = bit_index;
              lr = ctrl.repeats;
            end
          end else begin
            ctrl_next.line       = 1'b0;
            ctrl_next.tick_count = ctrl.tick_count + irpd_pkg::TICK_W'(1);
          end
        end
        irpd_pkg::PH_GAP: begin
          if (ctrl.tick_count >= cfg.end_gap) begin
            land_en = 1'b1;
          end else begin
            ctrl_next.line       = 1'b0;
            ctrl_next.tick_count = ctrl.tick_count + irpd_pkg::TICK_W'(1);
          end
        end
        default: begin
          ctrl_next.line = 1'b0;
        end
      endcase
      // Enter the landing segment and spend this tick in it
      if (land_en) begin
        ctrl_next.phase   = lp;
        ctrl_next.repeats = lr;
        bit_index_next    = li;
        case (lp)
          irpd_pkg::PH_HEADER, irpd_pkg::PH_MARK: begin
            ctrl_next.carrier_count = '0;
            ctrl_next.line          = 1'b1;
            ctrl_next.half_count    = (half_len == irpd_pkg::HALF_W'(1)) ?
                                      '0 : irpd_pkg::HALF_W'(1);
          end
          irpd_pkg::PH_SPACE, irpd_pkg::PH_GAP: begin
            ctrl_next.tick_count = irpd_pkg::TICK_W'(1);
            ctrl_next.line       = 1'b0;
          end
          default: begin
            ctrl_next.line = 1'b0;
          end
        endcase
      end
    end
    res.ir_level = ctrl_next.line;
    res.busy_res = (ctrl_next.phase != irpd_pkg::PH_IDLE);
  end

endmodule

[hw/rtl/irpd_out_buf.sv]
// Two-entry output register with skid stage; the input side ready is a
// register, so upstream never waits on the downstream ready path.
// No dependencies.
module irpd_out_buf #(
  parameter int WIDTH = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             push;
  logic             pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Control: refill the output from the skid first, else from the input
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

endmodule

[hw/rtl/ir_pulse_distance_transmitter.sv]
// Infrared pulse-distance transmitter top level: register file, sequencer
// state and output buffer. Depends on irpd_pkg, irpd_step, irpd_out_buf.
//
// Each input beat is either a start (tuser = 1, carrying the code and repeat
// count) or a one-microsecond tick (tuser = 0) that advances the transmit line
// by one tick. Every input beat yields exactly one result beat with the line
// level after that beat, a busy flag and a flag for a dropped start (sent
// while busy or with zero repeats). The block takes one beat per clock while
// its output buffer has room; the result is registered in the buffer's output
// stage, and its skid entry lets one more beat in while the output is stalled.
// The one-beat rate is set by the sequencer state register, which is updated
// by a single pass of next-state logic per beat, including the skip over any
// run of zero-length segments. Write the registers only while the block is
// idle; indexes beyond the list are ignored.
module ir_pulse_distance_transmitter #(
  parameter int CODE_BITS = 22
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_axis_tdata: [21:0] code_word, [29:22] repeat_count, [31:30] zero
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [irpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: [0] mode
  input  logic [irpd_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // m_axis_tdata: [0] ir_level, [1] busy_res, [2] start_rejected, [7:3] zero
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [irpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [irpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(CODE_BITS + 1);
  localparam int RES_W = $bits(irpd_pkg::res_t);

  irpd_pkg::cfg_t          cfg;
  irpd_pkg::ctrl_t         ctrl;
  irpd_pkg::ctrl_t         ctrl_next;
  logic [CODE_BITS-1:0]    code_shift;
  logic [CODE_BITS-1:0]    code_shift_next;
  logic [IDX_W-1:0]        bit_index;
  logic [IDX_W-1:0]        bit_index_next;
  irpd_pkg::res_t          res;
  irpd_pkg::res_t          out_res;
  logic                    s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_half  <= irpd_pkg::RST_CARRIER_HALF;
      cfg.header_cycles <= irpd_pkg::RST_HEADER_CYC;
      cfg.mark_cycles   <= irpd_pkg::RST_MARK_CYC;
      cfg.zero_space    <= irpd_pkg::RST_ZERO_SPACE;
      cfg.one_space     <= irpd_pkg::RST_ONE_SPACE;
      cfg.end_gap       <= irpd_pkg::RST_END_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        irpd_pkg::REG_CARRIER_HALF: cfg.carrier_half  <= cfg_data[irpd_pkg::HALF_W-1:0];
        irpd_pkg::REG_HEADER_CYC:   cfg.header_cycles <= cfg_data[irpd_pkg::CYCLES_W-1:0];
        irpd_pkg::REG_MARK_CYC:     cfg.mark_cycles   <= cfg_data[irpd_pkg::CYCLES_W-1:0];
        irpd_pkg::REG_ZERO_SPACE:   cfg.zero_space    <= cfg_data[irpd_pkg::SPACE_W-1:0];
        irpd_pkg::REG_ONE_SPACE:    cfg.one_space     <= cfg_data[irpd_pkg::SPACE_W-1:0];
        irpd_pkg::REG_END_GAP:      cfg.end_gap       <= cfg_data[irpd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Next-state logic for one beat
  irpd_step #(
    .CODE_BITS (CODE_BITS)
  ) u_step (
    .ctrl            (ctrl),
    .code_shift      (code_shift),
    .bit_index       (bit_index),
    .cfg             (cfg),
    .mode            (s_axis_tuser[0]),
    .code_word       (s_axis_tdata[irpd_pkg::CODE_WORD_W-1:0]),
    .repeat_count    (s_axis_tdata[irpd_pkg::CODE_WORD_W +: irpd_pkg::REPEAT_W]),
    .ctrl_next       (ctrl_next),
    .code_shift_next (code_shift_next),
    .bit_index_next  (bit_index_next),
    .res             (res)
  );

  // Sequencer state, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= '{phase: irpd_pkg::PH_IDLE, default: '0};
      code_shift <= '0;
      bit_index  <= '0;
    end else if (s_acc) begin
      ctrl       <= ctrl_next;
      code_shift <= code_shift_next;
      bit_index  <= bit_index_next;
    end
  end

  // Result buffer
  irpd_out_buf #(
    .WIDTH (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {{(irpd_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_res};

  // Input stalls only while a result is pending at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // The line rests low whenever nothing is being sent
  a_idle_line_low: assert property (@(posedge clk) disable iff (rst)
    ctrl.phase == irpd_pkg::PH_IDLE |-> !ctrl.line)
    else $error("line high while idle");

  // A dropped start leaves the sequencer untouched
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (s_acc && res.start_rejected) |=>
      (ctrl == $past(ctrl)) && (code_shift == $past(code_shift)) &&
      (bit_index == $past(bit_index)))
    else $error("rejected start changed the sequencer state");

  // A space always belongs to a real code bit
  a_space_bit_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.phase == irpd_pkg::PH_SPACE |-> bit_index < IDX_W'(CODE_BITS))
    else $error("space phase past the last code bit");

endmodule
